// ===== hdl/ptft_pkg.sv =====
package ptft_pkg;

  // fixed widths of the word fields
  localparam int VA_W        = 13;
  localparam int PA_W        = 12;
  localparam int FRAME_OUT_W = 2;
  localparam int EVP_W       = 3;

  // sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SPLIT,
    ST_READ,
    ST_LOOKUP,
    ST_EVICT
  } state_t;

endpackage

// ===== hdl/ptft_split.sv =====
module ptft_split import ptft_pkg::*; #(
  parameter int NUM_PAGES = 8,
  parameter int PAGE_SIZE = 1024,
  localparam int PAGE_W = $clog2(NUM_PAGES)
) (
  input  logic              clk,
  input  logic              load,
  input  logic [VA_W-1:0]   virtual_address,
  output logic [PAGE_W-1:0] page,
  output logic [VA_W-1:0]   offset
);

  // reciprocals for exact floor division of VA_W-bit values
  localparam int PS_K  = VA_W + $clog2(PAGE_SIZE);
  localparam longint unsigned PS_M = ((64'd1 << PS_K) + PAGE_SIZE - 1) / PAGE_SIZE;
  localparam int PS_PW = VA_W + PS_K + 2;
  localparam int NP_K  = VA_W + $clog2(NUM_PAGES);
  localparam longint unsigned NP_M = ((64'd1 << NP_K) + NUM_PAGES - 1) / NUM_PAGES;
  localparam int NP_PW = VA_W + NP_K + 2;

  logic [VA_W-1:0]  va_q;
  logic [VA_W-1:0]  quot_q;
  logic [VA_W-1:0]  wrap_q;
  logic [PS_PW-1:0] ps_prod;
  logic [NP_PW-1:0] np_prod;
  logic [VA_W-1:0]  off_calc;
  logic [VA_W-1:0]  page_full;

  // address divided by page size, taken when the word is accepted
  assign ps_prod = PS_PW'(virtual_address) * PS_PW'(PS_M);

  always_ff @(posedge clk) begin
    if (load) begin
      va_q   <= virtual_address;
      quot_q <= VA_W'(ps_prod >> PS_K);
    end
  end

  // second stage: offset and the wrap count of the page number
  assign np_prod  = NP_PW'(quot_q) * NP_PW'(NP_M);
  assign off_calc = va_q - VA_W'(32'(quot_q) * 32'(PAGE_SIZE));

  always_ff @(posedge clk) begin
    wrap_q <= VA_W'(np_prod >> NP_K);
    offset <= off_calc;
  end

  // page number folded into the table
  assign page_full = quot_q - VA_W'(32'(wrap_q) * 32'(NUM_PAGES));
  assign page      = page_full[PAGE_W-1:0];

endmodule

// ===== hdl/page_table_fifo_translate.sv =====
// Virtual to physical page translation with FIFO replacement. Raise start
// with virtual_address while busy is low; the word is taken at that edge and
// busy stays high until the result is on the ports. The result is shown for
// exactly one cycle with done high and must be captured then. A hit, or a
// fault that fills a free frame, raises done straight from the lookup; a
// fault that replaces the oldest frame passes through the evict state first.
// A new word can be accepted in the cycle done is high, but not before: each
// word goes through the two-stage address split (divide by page size, fold
// into the table), the registered read of the page table memory and, on
// replacement, a second write to that same single-port table. After reset
// the page table is cleared one entry a cycle, all NUM_PAGES entries, with
// busy high. On a fault physical_address is zero; evicted_page is zero
// unless evicted_valid is set.
module page_table_fifo_translate import ptft_pkg::*; #(
  parameter int NUM_PAGES  = 8,
  parameter int PAGE_SIZE  = 1024,
  parameter int NUM_FRAMES = 4
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [VA_W-1:0]        virtual_address,
  output logic                   busy,
  output logic                   done,
  output logic                   hit,
  output logic [PA_W-1:0]        physical_address,
  output logic [FRAME_OUT_W-1:0] frame,
  output logic                   evicted_valid,
  output logic [EVP_W-1:0]       evicted_page
);

  localparam int PAGE_W  = $clog2(NUM_PAGES);
  localparam int FRAME_W = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
  localparam int FU_W    = $clog2(NUM_FRAMES + 1);

  state_t state, state_next;

  logic [PAGE_W-1:0]  clr_cnt;
  logic [FU_W-1:0]    frames_used;
  logic [FRAME_W-1:0] fifo_victim;
  logic [FRAME_W-1:0] victim_next;

  // page table entry: present bit over frame number
  logic [FRAME_W:0]   pt_mem [NUM_PAGES];
  logic [FRAME_W:0]   pt_rdata;
  logic [FRAME_W:0]   pt_wdata;
  logic [PAGE_W-1:0]  pt_waddr;
  logic               pt_we;

  // owner page of each frame
  logic [PAGE_W-1:0]  fo_mem [NUM_FRAMES];
  logic [PAGE_W-1:0]  fo_rdata;
  logic [FRAME_W-1:0] fo_waddr;
  logic               fo_we;

  logic               rd_en;
  logic               split_load;
  logic               alloc;
  logic               evict;
  logic               res_load;
  logic               res_hit;
  logic [FRAME_W-1:0] res_frame;

  logic [PAGE_W-1:0]  page;
  logic [VA_W-1:0]    offset;
  logic [PAGE_W-1:0]  cur_page;
  logic [31:0]        pa_full;

  ptft_split #(
    .NUM_PAGES (NUM_PAGES),
    .PAGE_SIZE (PAGE_SIZE)
  ) u_split (
    .clk             (clk),
    .load            (split_load),
    .virtual_address (virtual_address),
    .page            (page),
    .offset          (offset)
  );

  assign busy = (state != ST_IDLE);

  assign victim_next = (fifo_victim == FRAME_W'(NUM_FRAMES - 1)) ? '0 : fifo_victim + 1'b1;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state and memory controls
  always_comb begin
    state_next = state;
    split_load = 1'b0;
    rd_en      = 1'b0;
    pt_we      = 1'b0;
    pt_waddr   = cur_page;
    pt_wdata   = {1'b1, fifo_victim};
    fo_we      = 1'b0;
    fo_waddr   = fifo_victim;
    alloc      = 1'b0;
    evict      = 1'b0;
    res_load   = 1'b0;
    res_hit    = 1'b0;
    res_frame  = fifo_victim;
    unique case (state)
      ST_CLEAR: begin
        pt_we    = 1'b1;
        pt_waddr = clr_cnt;
        pt_wdata = '0;
        if (clr_cnt == PAGE_W'(NUM_PAGES - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          split_load = 1'b1;
          state_next = ST_SPLIT;
        end
      end
      ST_SPLIT: begin
        state_next = ST_READ;
      end
      ST_READ: begin
        rd_en      = 1'b1;
        state_next = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        priority if (pt_rdata[FRAME_W]) begin
          res_hit    = 1'b1;
          res_frame  = pt_rdata[FRAME_W-1:0];
          res_load   = 1'b1;
          state_next = ST_IDLE;
        end else if (frames_used < FU_W'(NUM_FRAMES)) begin
          alloc      = 1'b1;
          res_frame  = frames_used[FRAME_W-1:0];
          pt_we      = 1'b1;
          pt_wdata   = {1'b1, frames_used[FRAME_W-1:0]};
          fo_we      = 1'b1;
          fo_waddr   = frames_used[FRAME_W-1:0];
          res_load   = 1'b1;
          state_next = ST_IDLE;
        end else begin
          // drop the old owner first, the new page goes in next cycle
          pt_we      = 1'b1;
          pt_waddr   = fo_rdata;
          pt_wdata   = '0;
          fo_we      = 1'b1;
          state_next = ST_EVICT;
        end
      end
      ST_EVICT: begin
        evict      = 1'b1;
        pt_we      = 1'b1;
        res_load   = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // page table memory
  always_ff @(posedge clk) begin
    if (pt_we) begin
      pt_mem[pt_waddr] <= pt_wdata;
    end
    if (rd_en) begin
      pt_rdata <= pt_mem[page];
    end
  end

  // frame owner memory, read at the next victim
  always_ff @(posedge clk) begin
    if (fo_we) begin
      fo_mem[fo_waddr] <= cur_page;
    end
    if (rd_en) begin
      fo_rdata <= fo_mem[fifo_victim];
    end
  end

  // clear counter, fill count and replacement pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt     <= '0;
      frames_used <= '0;
      fifo_victim <= '0;
    end else begin
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (alloc) begin
        frames_used <= frames_used + 1'b1;
      end
      if (evict) begin
        fifo_victim <= victim_next;
      end
    end
  end

  // page of the word in flight
  always_ff @(posedge clk) begin
    if (rd_en) begin
      cur_page <= page;
    end
  end

  // result word
  assign pa_full = 32'(res_frame) * 32'(PAGE_SIZE) + 32'(offset);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= res_load;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      hit              <= res_hit;
      physical_address <= res_hit ? pa_full[PA_W-1:0] : '0;
      frame            <= FRAME_OUT_W'(res_frame);
      evicted_valid    <= evict;
      evicted_page     <= evict ? EVP_W'(fo_rdata) : '0;
    end
  end

`ifndef ASSERT_OFF
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted word did not make the block busy");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while still busy");

  a_evict_full: assert property (@(posedge clk) disable iff (rst)
    (done && evicted_valid) |-> (frames_used == FU_W'(NUM_FRAMES)))
    else $error("eviction before all frames were filled");

  a_hit_clean: assert property (@(posedge clk) disable iff (rst)
    (done && hit) |-> (!evicted_valid && evicted_page == '0))
    else $error("hit reported an eviction");
`endif

endmodule

// ===== tb/sv/tb_top.sv =====
module tb_top;
  import ptft_pkg::*;

  localparam int NUM_PAGES       = 8;
  localparam int NUM_FRAMES      = 4;
  localparam int OFS_W           = 10;
  localparam int PAGE_W          = 3;
  localparam int WORDS_PER_PHASE = 645;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int DRAIN_CYCLES    = 12;
  localparam int N_DIRECTED      = 18;

  // one translation result word
  typedef struct packed {
    logic                   hit;
    logic [PA_W-1:0]        pa;
    logic [FRAME_OUT_W-1:0] frame;
    logic                   ev_valid;
    logic [EVP_W-1:0]       ev_page;
  } xlat_t;

  // directed stimulus row; typed rows carry their result, the rest use the predictor
  typedef struct packed {
    logic [VA_W-1:0] va;
    logic            typed;
    xlat_t           want;
  } stim_row_t;

  localparam stim_row_t DIRECTED [N_DIRECTED] = '{
    '{13'h0000, 1'b1, '{1'b0, 12'h000, 2'd0, 1'b0, 3'd0}},  // first fault fills frame 0
    '{13'h03FF, 1'b1, '{1'b1, 12'h3FF, 2'd0, 1'b0, 3'd0}},  // hit, top offset
    '{13'h1FFF, 1'b1, '{1'b0, 12'h000, 2'd1, 1'b0, 3'd0}},  // top page faults
    '{13'h1C00, 1'b1, '{1'b1, 12'h400, 2'd1, 1'b0, 3'd0}},
    '{13'h1FFF, 1'b1, '{1'b1, 12'h7FF, 2'd1, 1'b0, 3'd0}},
    '{13'h0800, 1'b0, '0},
    '{13'h0C00, 1'b0, '0},                                    // last free frame
    '{13'h0FFF, 1'b1, '{1'b1, 12'hFFF, 2'd3, 1'b0, 3'd0}},  // largest physical address
    '{13'h1000, 1'b1, '{1'b0, 12'h000, 2'd0, 1'b1, 3'd0}},  // first replacement
    '{13'h0000, 1'b1, '{1'b0, 12'h000, 2'd1, 1'b1, 3'd7}},  // evicted page comes back
    '{13'h1FFF, 1'b1, '{1'b0, 12'h000, 2'd2, 1'b1, 3'd2}},
    '{13'h1400, 1'b0, '0},
    '{13'h1800, 1'b0, '0},                                    // victim pointer wraps
    '{13'h1555, 1'b1, '{1'b1, 12'hD55, 2'd3, 1'b0, 3'd0}},
    '{13'h02AA, 1'b0, '0},
    '{13'h0AAA, 1'b1, '{1'b0, 12'h000, 2'd1, 1'b1, 3'd0}},
    '{13'h0AAA, 1'b0, '0},
    '{13'h1234, 1'b0, '0}
  };

  logic                   clk;
  logic                   rst;
  logic                   start;
  logic [VA_W-1:0]        virtual_address;
  logic                   busy;
  logic                   done;
  logic                   hit;
  logic [PA_W-1:0]        physical_address;
  logic [FRAME_OUT_W-1:0] frame;
  logic                   evicted_valid;
  logic [EVP_W-1:0]       evicted_page;

  page_table_fifo_translate u_top (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .virtual_address  (virtual_address),
    .busy             (busy),
    .done             (done),
    .hit              (hit),
    .physical_address (physical_address),
    .frame            (frame),
    .evicted_valid    (evicted_valid),
    .evicted_page     (evicted_page)
  );

  // predicted page table contents
  logic                   resident [NUM_PAGES];
  logic [FRAME_OUT_W-1:0] frame_of [NUM_PAGES];
  logic [PAGE_W-1:0]      owner_of [NUM_FRAMES];
  logic [2:0]             filled_frames;
  logic [1:0]             next_victim;

  xlat_t             pending_xlat [$];
  int                mismatches;
  int                idle_pct;
  logic [PAGE_W-1:0] hot_base;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // translate one address and advance the predicted table
  function automatic xlat_t translate_page(input logic [VA_W-1:0] va);
    logic [PAGE_W-1:0] page;
    logic [OFS_W-1:0]  ofs;
    xlat_t             r;
    page = va[VA_W-1:OFS_W];
    ofs  = va[OFS_W-1:0];
    r    = '0;
    if (resident[page]) begin
      r.hit   = 1'b1;
      r.frame = frame_of[page];
      r.pa    = {frame_of[page], ofs};
    end else begin
      if (filled_frames < NUM_FRAMES) begin
        r.frame       = filled_frames[1:0];
        filled_frames = filled_frames + 3'd1;
      end else begin
        // reuse the oldest frame and drop its page
        r.frame                     = next_victim;
        r.ev_valid                  = 1'b1;
        r.ev_page                   = owner_of[next_victim];
        resident[owner_of[next_victim]] = 1'b0;
        next_victim                 = next_victim + 2'd1;
      end
      owner_of[r.frame] = page;
      resident[page]    = 1'b1;
      frame_of[page]    = r.frame;
    end
    return r;
  endfunction

  // random address, mostly from a drifting window of pages to mix hits and faults
  function automatic logic [VA_W-1:0] pick_address();
    logic [PAGE_W-1:0] page;
    logic [OFS_W-1:0]  ofs;
    if ($urandom_range(0, 19) == 0) hot_base = PAGE_W'($urandom_range(0, NUM_PAGES - 1));
    if ($urandom_range(0, 99) < 75) page = hot_base + PAGE_W'($urandom_range(0, 4));
    else page = PAGE_W'($urandom_range(0, NUM_PAGES - 1));
    case ($urandom_range(0, 9))
      0: ofs = '0;
      1: ofs = '1;
      default: ofs = OFS_W'($urandom_range(0, (1 << OFS_W) - 1));
    endcase
    return {page, ofs};
  endfunction

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("mismatch: %s got %0d expected %0d", what, got, want);
    mismatches++;
  endtask

  // four-state compare so an unknown on a result port is caught
  task automatic check_field(input string what, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) flag_mismatch(what, got, want);
  endtask

  // present one word, called and returning at a falling edge
  task automatic send_word(input logic [VA_W-1:0] va, input logic typed, input xlat_t want);
    xlat_t predicted;
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start           <= 1'b1;
    virtual_address <= va;
    @(posedge clk);
    while (busy) @(posedge clk);
    predicted = translate_page(va);
    pending_xlat.push_back(typed ? want : predicted);
    @(negedge clk);
  endtask

  // hold off until every expected word has come back
  task automatic drain_pause();
    start <= 1'b0;
    while (pending_xlat.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // compare each result word with the oldest expectation
  always @(posedge clk) begin : check_results
    xlat_t want;
    if (!rst && done) begin
      if (pending_xlat.size() == 0) begin
        flag_mismatch("result word with nothing expected, hit", hit, 0);
      end else begin
        want = pending_xlat.pop_front();
        check_field("hit", hit, want.hit);
        check_field("physical_address", physical_address, want.pa);
        check_field("frame", frame, want.frame);
        check_field("evicted_valid", evicted_valid, want.ev_valid);
        check_field("evicted_page", evicted_page, want.ev_page);
      end
    end
  end

  // watchdog
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb_top failed");
    $finish;
  end

  initial begin : stimulus
    rst             = 1'b1;
    start           = 1'b0;
    virtual_address = '0;
    mismatches      = 0;
    idle_pct        = 31;
    hot_base        = '0;
    filled_frames   = '0;
    next_victim     = '0;
    for (int p = 0; p < NUM_PAGES; p++) begin
      resident[p] = 1'b0;
      frame_of[p] = '0;
    end
    for (int f = 0; f < NUM_FRAMES; f++) owner_of[f] = '0;

    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // directed walk through fill, hit and replacement
    for (int i = 0; i < N_DIRECTED; i++) begin
      send_word(DIRECTED[i].va, DIRECTED[i].typed, DIRECTED[i].want);
    end
    drain_pause();

    // random phases: light sender gaps, heavy gaps, back to back
    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 31 : (phase == 1) ? 71 : 0;
      for (int n = 0; n < WORDS_PER_PHASE; n++) send_word(pick_address(), 1'b0, '0);
      drain_pause();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
